@@ rtl/audio_input_gain_dc_block_gate_top_assert.svh @@
// Assertion macros used by the checker of the audio input stage.
`ifndef AUDIO_INPUT_GAIN_DC_BLOCK_GATE_TOP_ASSERT_SVH
`define AUDIO_INPUT_GAIN_DC_BLOCK_GATE_TOP_ASSERT_SVH

// Antecedent and consequent in the same cycle, ignored while in reset.
`define AGDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent, ignored while in reset.
`define AGDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent, checked through reset as well.
`define AGDG_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/agdg_pkg.sv @@
// Package with types and constants of the audio input gain, DC blocker and noise gate.
package agdg_pkg;

  // Sample width default.
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int COEF_W     = 16;
  localparam int THRESH_W   = 23;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DC_POLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 3'd4;

  // Register reset values.
  localparam logic [COEF_W-1:0]   INPUT_GAIN_RST     = 16'd4096;
  localparam logic [COEF_W-1:0]   DC_POLE_RST        = 16'd65450;
  localparam logic [COEF_W-1:0]   ATTACK_COEF_RST    = 16'd65264;
  localparam logic [COEF_W-1:0]   RELEASE_COEF_RST   = 16'd65519;
  localparam logic [THRESH_W-1:0] GATE_THRESHOLD_RST = 23'd8389;

  // Datapath widths.
  localparam int ACC_W    = 32;
  localparam int GAIN_W   = 17;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // Gate gain constants, Q1.16.
  localparam logic [GAIN_W-1:0] GATE_UNITY = 17'd65536;
  localparam logic [MUL_B_W-1:0] GATE_STEP = 18'd655;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_DC,
    ST_Y,
    ST_ENV_MUL,
    ST_ENV,
    ST_GATE_MUL,
    ST_GATE,
    ST_OUT_MUL,
    ST_OUT
  } agdg_state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_GAIN,
    OP_DC,
    OP_Y,
    OP_ENV_MUL,
    OP_ENV,
    OP_GATE_MUL,
    OP_GATE,
    OP_OUT_MUL
  } agdg_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_sample;
    agdg_op_t op;
    logic     out_load;
  } agdg_cmd_t;

endpackage

@@ rtl/agdg_ctrl.sv @@
// Controller state machine that sequences one sample through the shared multiplier.
module agdg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output agdg_pkg::agdg_cmd_t cmd
);

  agdg_pkg::agdg_state_t state;
  agdg_pkg::agdg_state_t state_next;
  logic                  out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= agdg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '{load_sample: 1'b0, op: agdg_pkg::OP_NONE, out_load: 1'b0};
    unique case (state)
      agdg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = agdg_pkg::ST_GAIN;
        end
      end
      agdg_pkg::ST_GAIN: begin
        cmd.op     = agdg_pkg::OP_GAIN;
        state_next = agdg_pkg::ST_DC;
      end
      agdg_pkg::ST_DC: begin
        cmd.op     = agdg_pkg::OP_DC;
        state_next = agdg_pkg::ST_Y;
      end
      agdg_pkg::ST_Y: begin
        cmd.op     = agdg_pkg::OP_Y;
        state_next = agdg_pkg::ST_ENV_MUL;
      end
      agdg_pkg::ST_ENV_MUL: begin
        cmd.op     = agdg_pkg::OP_ENV_MUL;
        state_next = agdg_pkg::ST_ENV;
      end
      agdg_pkg::ST_ENV: begin
        cmd.op     = agdg_pkg::OP_ENV;
        state_next = agdg_pkg::ST_GATE_MUL;
      end
      agdg_pkg::ST_GATE_MUL: begin
        cmd.op     = agdg_pkg::OP_GATE_MUL;
        state_next = agdg_pkg::ST_GATE;
      end
      agdg_pkg::ST_GATE: begin
        cmd.op     = agdg_pkg::OP_GATE;
        state_next = agdg_pkg::ST_OUT_MUL;
      end
      agdg_pkg::ST_OUT_MUL: begin
        cmd.op     = agdg_pkg::OP_OUT_MUL;
        state_next = agdg_pkg::ST_OUT;
      end
      agdg_pkg::ST_OUT: begin
        // The result moves into the output register once that register is free.
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = agdg_pkg::ST_IDLE;
        end
      end
      default: state_next = agdg_pkg::ST_IDLE;
    endcase
    out_valid_next = cmd.out_load || (out_valid && out_stall);
  end

endmodule

@@ rtl/agdg_datapath.sv @@
// Datapath: configuration registers, filter state, shared multiplier and output register.
module agdg_datapath #(
  parameter int SAMPLE_BITS = agdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  agdg_pkg::agdg_cmd_t              cmd,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in,
  output logic signed [SAMPLE_BITS-1:0]    sample_out,
  input  logic                             cfg_write,
  input  logic [agdg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [agdg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = agdg_pkg::PROD_W;
  localparam int AW = agdg_pkg::MUL_A_W;
  localparam int BW = agdg_pkg::MUL_B_W;
  localparam int CW = agdg_pkg::ACC_W;
  localparam int GW = agdg_pkg::GAIN_W;

  localparam logic signed [PW-1:0] ACC_HI = PW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [PW-1:0] ACC_LO = PW'(-64'sh0000_0000_8000_0000);
  localparam logic signed [PW-1:0] S_HI   = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] S_LO   = PW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [PW-1:0] RND_12 = PW'(2048);
  localparam logic signed [PW-1:0] RND_16 = PW'(32768);
  localparam logic signed [PW-1:0] CEIL_16 = PW'(65535);

  // Clamp a wide value to the 32-bit signed range.
  function automatic logic signed [CW-1:0] sat_acc(input logic signed [PW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > ACC_HI) begin
      r = ACC_HI[CW-1:0];
    end else if (v < ACC_LO) begin
      r = ACC_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [agdg_pkg::COEF_W-1:0]   input_gain;
  logic [agdg_pkg::COEF_W-1:0]   dc_pole;
  logic [agdg_pkg::COEF_W-1:0]   attack_coef;
  logic [agdg_pkg::COEF_W-1:0]   release_coef;
  logic [agdg_pkg::THRESH_W-1:0] gate_threshold;

  // Filter state and working registers.
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [CW-1:0]          gained;
  logic signed [CW-1:0]          prev_x;
  logic signed [CW-1:0]          prev_y;
  logic [CW-1:0]                 envelope;
  logic [GW-1:0]                 gate_gain;
  logic                          gate_up;
  logic signed [PW-1:0]          prod;

  // Combinational terms.
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic                 mul_en;
  logic signed [AW-1:0] y_abs;
  logic                 rising;
  logic [agdg_pkg::COEF_W-1:0] coef;
  logic [GW-1:0]        coef_comp;
  logic signed [AW-1:0] env_diff;
  logic                 gate_open;
  logic signed [BW-1:0] gate_diff;
  logic [GW-1:0]        gate_mag;
  logic signed [PW-1:0] x_wide;
  logic signed [PW-1:0] y_wide;
  logic signed [PW-1:0] env_wide;
  logic signed [PW-1:0] step_wide;
  logic [GW-1:0]        step;
  logic signed [PW-1:0] out_wide;
  logic signed [PW-1:0] out_sat;

  // Envelope follower and gate terms.
  always_comb begin
    y_abs     = prev_y[CW-1] ? -AW'(prev_y) : AW'(prev_y);
    rising    = y_abs > $signed({1'b0, envelope});
    coef      = rising ? attack_coef : release_coef;
    coef_comp = GW'(agdg_pkg::GATE_UNITY - {1'b0, coef});
    env_diff  = y_abs - $signed({1'b0, envelope});
    gate_open = envelope > {{(CW - agdg_pkg::THRESH_W){1'b0}}, gate_threshold};
    gate_diff = (gate_open ? $signed({1'b0, agdg_pkg::GATE_UNITY}) : '0)
              - $signed({1'b0, gate_gain});
    gate_mag  = gate_diff[BW-1] ? GW'(-gate_diff) : GW'(gate_diff);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (cmd.op)
      agdg_pkg::OP_GAIN: begin
        mul_a  = AW'(sample);
        mul_b  = $signed({2'b00, input_gain});
        mul_en = 1'b1;
      end
      agdg_pkg::OP_DC: begin
        mul_a  = AW'(prev_y);
        mul_b  = $signed({2'b00, dc_pole});
        mul_en = 1'b1;
      end
      agdg_pkg::OP_ENV_MUL: begin
        mul_a  = env_diff;
        mul_b  = $signed({1'b0, coef_comp});
        mul_en = 1'b1;
      end
      agdg_pkg::OP_GATE_MUL: begin
        mul_a  = $signed({{(AW - GW){1'b0}}, gate_mag});
        mul_b  = $signed(agdg_pkg::GATE_STEP);
        mul_en = 1'b1;
      end
      agdg_pkg::OP_OUT_MUL: begin
        mul_a  = AW'(prev_y);
        mul_b  = $signed({1'b0, gate_gain});
        mul_en = 1'b1;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Rounding, saturation and update terms taken from the product register.
  always_comb begin
    x_wide    = (prod + RND_12) >>> 12;
    y_wide    = PW'(gained) - PW'(prev_x) + ((prod + RND_16) >>> 16);
    env_wide  = $signed({{(PW - CW){1'b0}}, envelope}) + (prod >>> 16);
    step_wide = (prod + CEIL_16) >>> 16;
    step      = step_wide[GW-1:0];
    out_wide  = (prod + RND_16) >>> 16;
    if (out_wide > S_HI) begin
      out_sat = S_HI;
    end else if (out_wide < S_LO) begin
      out_sat = S_LO;
    end else begin
      out_sat = out_wide;
    end
  end

  // Shared multiplier with its product register; operands are sign-extended to full width.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // Captured sample, output payload, gained value and gate direction.
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample <= sample_in;
    end
    if (cmd.out_load) begin
      sample_out <= out_sat[SAMPLE_BITS-1:0];
    end
    if (cmd.op == agdg_pkg::OP_DC) begin
      gained <= sat_acc(x_wide);
    end
    if (cmd.op == agdg_pkg::OP_GATE_MUL) begin
      gate_up <= !gate_diff[BW-1];
    end
  end

  // Configuration registers and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain     <= agdg_pkg::INPUT_GAIN_RST;
      dc_pole        <= agdg_pkg::DC_POLE_RST;
      attack_coef    <= agdg_pkg::ATTACK_COEF_RST;
      release_coef   <= agdg_pkg::RELEASE_COEF_RST;
      gate_threshold <= agdg_pkg::GATE_THRESHOLD_RST;
      prev_x         <= '0;
      prev_y         <= '0;
      envelope       <= '0;
      gate_gain      <= agdg_pkg::GATE_UNITY;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          agdg_pkg::REG_INPUT_GAIN:     input_gain     <= cfg_data[agdg_pkg::COEF_W-1:0];
          agdg_pkg::REG_DC_POLE:        dc_pole        <= cfg_data[agdg_pkg::COEF_W-1:0];
          agdg_pkg::REG_ATTACK_COEF:    attack_coef    <= cfg_data[agdg_pkg::COEF_W-1:0];
          agdg_pkg::REG_RELEASE_COEF:   release_coef   <= cfg_data[agdg_pkg::COEF_W-1:0];
          agdg_pkg::REG_GATE_THRESHOLD: gate_threshold <= cfg_data[agdg_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end
      // Blocker output becomes the previous output, which later steps also use as y.
      if (cmd.op == agdg_pkg::OP_Y) begin
        prev_x <= gained;
        prev_y <= sat_acc(y_wide);
      end
      if (cmd.op == agdg_pkg::OP_ENV) begin
        envelope <= env_wide[CW-1:0];
      end
      // The rounded-up step never exceeds the distance to the target.
      if (cmd.op == agdg_pkg::OP_GATE) begin
        gate_gain <= gate_up ? GW'(gate_gain + step) : GW'(gate_gain - step);
      end
    end
  end

endmodule

@@ rtl/audio_input_gain_dc_block_gate_top.sv @@
// Top level of the audio input stage: input gain, DC blocker and noise gate.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   sample_in
//   output    out        out_valid / out_stall sample_out
//   config    in         cfg_write             cfg_index, cfg_data
//
// After a transfer, one sample passes through nine sequencer steps before the input
// is free again; five of them use the single shared multiplier,
// and each product is registered before use.
// The result lands in an output register, so the next sample is taken while it waits.
// Reset is synchronous; state returns to unity gate gain with cleared filter history.
// A stalled output holds the sequencer in its last step until the register frees.
module audio_input_gain_dc_block_gate_top #(
  parameter int SAMPLE_BITS = agdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   sample_out,
  input  logic                            cfg_write,
  input  logic [agdg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agdg_pkg::CFG_DATA_W-1:0] cfg_data
);

  agdg_pkg::agdg_cmd_t cmd;

  // Sequencer.
  agdg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  agdg_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

@@ rtl/agdg_checker.sv @@
// Port-level checker for the audio input stage, bound to the top level.
`include "audio_input_gain_dc_block_gate_top_assert.svh"

module agdg_checker #(
  parameter int SAMPLE_BITS = agdg_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] sample_out
);

  // A stalled result stays valid and unchanged.
  `AGDG_ASSERT_NEXT(out_hold_a, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result changed")

  // Reset leaves no result pending and the input open.
  `AGDG_ASSERT_ALWAYS(reset_clear_a, rst, !out_valid && !in_stall, "state after reset wrong")

  // An input transfer starts work, so the input closes on the next cycle.
  `AGDG_ASSERT_NEXT(busy_after_accept_a, in_valid && !in_stall, in_stall, "input open while busy")

  // A new result only appears at the end of a busy period.
  `AGDG_ASSERT_NOW(result_from_work_a, $rose(out_valid), $past(in_stall), "result without work")

endmodule

bind audio_input_gain_dc_block_gate_top agdg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);
